[hw/rtl/modebit_frame_receiver_macros.svh]
// Assertion helpers shared by the receiver modules.
`ifndef MODEBIT_FRAME_RECEIVER_MACROS_SVH
`define MODEBIT_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mfr_pkg.sv]
package mfr_pkg;

    localparam int ByteW   = 8;
    localparam int CountW  = 8;
    localparam int SetSize = 3;
    localparam int SetCntW = 2;

    typedef enum logic [1:0] {
        CFG_MARKER = 2'd0,
        CFG_ACK    = 2'd1,
        CFG_NAK    = 2'd2,
        CFG_RET    = 2'd3
    } mfr_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ACK       = 3'd1,
        ST_NAK       = 3'd2,
        ST_RET       = 3'd3,
        ST_INVALID   = 3'd4,
        ST_BAD_SUM   = 3'd5,
        ST_UNKNOWN   = 3'd6
    } mfr_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } mfr_kind_t;

    typedef struct packed {
        logic [2*ByteW-1:0] marker;
        logic [ByteW-1:0]   ack;
        logic [ByteW-1:0]   nak;
        logic [ByteW-1:0]   ret;
    } mfr_cfg_t;

    typedef struct packed {
        mfr_kind_t          kind;
        logic [ByteW-1:0]   data;
        mfr_status_t        status;
        logic [CountW-1:0]  count;
    } mfr_item_t;

    typedef struct packed {
        logic [SetCntW-1:0]            n;
        mfr_item_t [SetSize-1:0]       item;
    } mfr_set_t;

endpackage

[hw/rtl/mfr_cfg_regs.sv]
module mfr_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output mfr_pkg::mfr_cfg_t cfg
);
    import mfr_pkg::*;

    mfr_cfg_t cfg_reg;
    mfr_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (mfr_cfg_idx_t'(cfg_index))
                CFG_MARKER: cfg_next.marker = cfg_data;
                CFG_ACK:    cfg_next.ack    = cfg_data[ByteW-1:0];
                CFG_NAK:    cfg_next.nak    = cfg_data[ByteW-1:0];
                CFG_RET:    cfg_next.ret    = cfg_data[ByteW-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.marker <= 16'hFF00;
            cfg_reg.ack    <= 8'h00;
            cfg_reg.nak    <= 8'hFF;
            cfg_reg.ret    <= 8'hAA;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/mfr_deframe.sv]
`include "modebit_frame_receiver_macros.svh"

module mfr_deframe #(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfr_pkg::mfr_cfg_t cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_byte,
    input  logic              s_end,
    input  logic              buf_free,
    output logic              load,
    output mfr_pkg::mfr_set_t set
);
    import mfr_pkg::*;

    localparam logic [CountW-1:0] MaxRaw = CountW'(MAX_FRAME_BYTES);

    logic              in_valid_reg;
    logic [ByteW-1:0]  in_byte_reg;
    logic              in_end_reg;

    logic [1:0]        esc_reg,  esc_next;
    logic              held_reg, held_next;
    logic [ByteW-1:0]  cand_reg, cand_next;
    logic              cand_v_reg, cand_v_next;
    logic [ByteW-1:0]  sum_reg,  sum_next;
    logic [CountW-1:0] raw_reg,  raw_next;
    logic [CountW-1:0] emit_reg, emit_next;
    logic              swm_reg,  swm_next;

    mfr_set_t set_next;

    assign load     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || load;
    assign set      = set_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_byte;
            in_end_reg  <= s_end;
        end
    end

    always_comb begin
        logic [ByteW-1:0] hi;
        logic [ByteW-1:0] lo;
        logic [ByteW-1:0] b;
        logic             push_a;
        logic             push_b;
        logic [ByteW-1:0] pa;
        logic [ByteW-1:0] pb;
        mfr_status_t      st;
        logic [CountW-1:0] cnt;

        hi = cfg.marker[2*ByteW-1:ByteW];
        lo = cfg.marker[ByteW-1:0];
        b  = in_byte_reg;
        push_a = 1'b0;
        push_b = 1'b0;
        pa = b;
        pb = b;
        st  = ST_UNKNOWN;
        cnt = '0;

        esc_next    = esc_reg;
        held_next   = held_reg;
        cand_next   = cand_reg;
        cand_v_next = cand_v_reg;
        sum_next    = sum_reg;
        raw_next    = raw_reg;
        emit_next   = emit_reg;
        swm_next    = swm_reg;
        set_next    = '0;

        if (raw_reg >= MaxRaw) begin
            if (in_end_reg) begin
                set_next.item[0].kind   = KIND_STATUS;
                set_next.item[0].status = ST_UNKNOWN;
                set_next.n = 2'd1;
            end
        end else begin
            raw_next = raw_reg + 1'b1;
            if (raw_reg == '0) begin
                swm_next = (b == hi);
            end else if (raw_reg == CountW'(1)) begin
                swm_next = swm_reg && (b == lo);
            end

            if (esc_reg == 2'd1) begin
                push_a   = 1'b1;
                esc_next = 2'd0;
            end else if (held_reg) begin
                held_next = 1'b0;
                if (b == lo) begin
                    if (!in_end_reg) begin
                        esc_next = 2'd1;
                    end
                end else begin
                    push_a = 1'b1;
                    pa     = hi;
                    if (!in_end_reg && b == hi) begin
                        held_next = 1'b1;
                    end else begin
                        push_b = 1'b1;
                    end
                end
            end else if (!in_end_reg && b == hi) begin
                held_next = 1'b1;
            end else begin
                push_a = 1'b1;
            end

            if (push_a) begin
                if (cand_v_next) begin
                    set_next.item[set_next.n].data = cand_next;
                    set_next.n = set_next.n + 1'b1;
                    sum_next   = sum_next + cand_next;
                    if (emit_next != '1) begin
                        emit_next = emit_next + 1'b1;
                    end
                end
                cand_next   = pa;
                cand_v_next = 1'b1;
            end
            if (push_b) begin
                if (cand_v_next) begin
                    set_next.item[set_next.n].data = cand_next;
                    set_next.n = set_next.n + 1'b1;
                    sum_next   = sum_next + cand_next;
                    if (emit_next != '1) begin
                        emit_next = emit_next + 1'b1;
                    end
                end
                cand_next   = pb;
                cand_v_next = 1'b1;
            end

            if (in_end_reg) begin
                if (raw_next < CountW'(3)) begin
                    st = ST_UNKNOWN;
                end else if (raw_next == CountW'(3)) begin
                    if (!swm_next) begin
                        st = ST_UNKNOWN;
                    end else if (b == cfg.ack) begin
                        st = ST_ACK;
                    end else if (b == cfg.nak) begin
                        st = ST_NAK;
                    end else if (b == cfg.ret) begin
                        st = ST_RET;
                    end else begin
                        st = ST_INVALID;
                    end
                end else begin
                    st  = (cand_v_next && sum_next == cand_next) ? ST_OK : ST_BAD_SUM;
                    cnt = emit_next;
                end
                set_next.item[set_next.n].kind   = KIND_STATUS;
                set_next.item[set_next.n].status = st;
                set_next.item[set_next.n].count  = cnt;
                set_next.n = set_next.n + 1'b1;
            end
        end

        if (in_end_reg) begin
            esc_next    = 2'd0;
            held_next   = 1'b0;
            cand_next   = '0;
            cand_v_next = 1'b0;
            sum_next    = '0;
            raw_next    = '0;
            emit_next   = '0;
            swm_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg    <= 2'd0;
            held_reg   <= 1'b0;
            cand_reg   <= '0;
            cand_v_reg <= 1'b0;
            sum_reg    <= '0;
            raw_reg    <= '0;
            emit_reg   <= '0;
            swm_reg    <= 1'b0;
        end else if (load) begin
            esc_reg    <= esc_next;
            held_reg   <= held_next;
            cand_reg   <= cand_next;
            cand_v_reg <= cand_v_next;
            sum_reg    <= sum_next;
            raw_reg    <= raw_next;
            emit_reg   <= emit_next;
            swm_reg    <= swm_next;
        end
    end

    `MFR_ASSERT_NEXT(a_end_clears, load && in_end_reg, raw_reg == '0 && !held_reg && esc_reg == 2'd0 && !cand_v_reg, "frame state not cleared after frame end")
    `MFR_ASSERT_NOW(a_held_or_escape, 1'b1, !(held_reg && esc_reg != 2'd0), "held marker byte and escape phase both set")

endmodule

[hw/rtl/mfr_out_buf.sv]
`include "modebit_frame_receiver_macros.svh"

module mfr_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mfr_pkg::mfr_set_t set,
    output logic              buf_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import mfr_pkg::*;

    mfr_item_t [SetSize-1:0] items_reg;
    logic [SetCntW-1:0]      cnt_reg;
    logic [SetCntW-1:0]      ptr_reg;
    mfr_item_t               head;

    assign head     = items_reg[ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == SetCntW'(1));
    assign m_tuser  = head.kind;
    assign m_tdata  = {5'd0, head.count, head.status, head.data};
    assign buf_free = (cnt_reg == '0) || (cnt_reg == SetCntW'(1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else if (load) begin
            cnt_reg <= set.n;
            ptr_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - 1'b1;
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= set.item;
        end
    end

    `MFR_ASSERT_NOW(a_ptr_in_range, 1'b1, ({1'b0, cnt_reg} + {1'b0, ptr_reg}) <= 3'd3, "result set pointer ran past its entries")
    `MFR_ASSERT_NOW(a_status_last, m_tvalid && head.kind == KIND_STATUS, cnt_reg == SetCntW'(1), "status word is not the last of its set")

endmodule

[hw/rtl/modebit_frame_receiver.sv]
// Channel  Direction  Width   Contents
// s_       in         8+1     tdata: rx_byte[7:0]; tlast: frame_end
// m_       out        24+1+1  tdata: payload_byte, frame_status, payload_count;
//                             tuser: item_kind; tlast: last_of_run
// cfg_     in         2+16    cfg_index selects the register, cfg_data the value
// One byte is taken per cycle when the output keeps up; it is registered in the input register
// and its results in the result buffer, one word per cycle on the m_ side while m_tready is high.
// A byte that gives two or three words holds the input until the result buffer, which drains
// one word per cycle while m_tready is high, is down to its last word and m_tready is high.
// Reset is synchronous on aresetn low and clears the frame state and the buffer.
// A stall on m_tready stops the buffer and then the input register.
module modebit_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_byte[7:0], frame_status[10:8], payload_count[18:11]
    output logic        m_tuser,   // item_kind[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mfr_pkg::*;

    mfr_cfg_t cfg;
    mfr_set_t set;
    logic     load;
    logic     buf_free;

    mfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfr_deframe #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_deframe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_end    (s_tlast),
        .buf_free (buf_free),
        .load     (load),
        .set      (set)
    );

    mfr_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .set      (set),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
